/* hw/rtl/lirm_pkg.sv */
// Package for the lookup-table YUV422 remap block.
// It holds the widths, store geometry, register indexes, lane types and address helpers.
// It has no dependencies.
package lirm_pkg;

    localparam int MAX_WIDTH   = 640;
    localparam int MAX_HEIGHT  = 480;
    localparam int CSTRIDE     = MAX_WIDTH / 2;
    localparam int STORE_DEPTH = CSTRIDE * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int X_W         = 10;
    localparam int Y_W         = 9;
    localparam int PIX_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [PIX_W-1:0] MARK_U = 8'd0;
    localparam logic [PIX_W-1:0] MARK_V = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_MARK_UNMAPPED = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] luma_idx;
        logic [ADDR_W-1:0] chroma_idx;
        logic              bank_odd;
        logic              marked;
    } lane_req_t;

    typedef struct packed {
        logic bank_odd;
        logic marked;
    } lane_sel_t;

    function automatic logic [ADDR_W-1:0] pair_index(input logic [Y_W-1:0] y,
                                                     input logic [X_W-2:0] x_half);
        pair_index = ADDR_W'(y) * ADDR_W'(CSTRIDE) + ADDR_W'(x_half);
    endfunction

    function automatic logic [X_W-1:0] eff_width(input logic [X_W-1:0] value);
        logic [X_W-1:0] w;
        w = {value[X_W-1:1], 1'b0};
        if (w < X_W'(2)) w = X_W'(2);
        if (w > X_W'(MAX_WIDTH)) w = X_W'(MAX_WIDTH);
        eff_width = w;
    endfunction

    function automatic logic [Y_W-1:0] eff_height(input logic [Y_W-1:0] value);
        logic [Y_W-1:0] h;
        h = value;
        if (h < Y_W'(1)) h = Y_W'(1);
        if (h > Y_W'(MAX_HEIGHT)) h = Y_W'(MAX_HEIGHT);
        eff_height = h;
    endfunction

endpackage

/* hw/rtl/lirm_ram.sv */
// Generic RAM with one write port and two registered read ports.
// It has no dependencies.
module lirm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* hw/rtl/lirm_lane.sv */
// One pixel lane of the remap block: saturates the source coordinate and forms the store addresses.
// It depends on lirm_pkg.
module lirm_lane (
    input  logic                         clk,
    input  logic [lirm_pkg::X_W-1:0]     map_x,
    input  logic [lirm_pkg::Y_W-1:0]     map_y,
    input  logic [lirm_pkg::X_W-1:0]     width,
    input  logic [lirm_pkg::Y_W-1:0]     height,
    input  logic                         mark_en,
    input  logic                         odd_pixel,
    input  logic [lirm_pkg::ADDR_W-1:0]  dest_idx,
    output lirm_pkg::lane_req_t          req
);

    logic [lirm_pkg::X_W-1:0]  sx;
    logic [lirm_pkg::Y_W-1:0]  sy;
    logic [lirm_pkg::ADDR_W-1:0] src_idx;
    lirm_pkg::lane_req_t       req_next;
    lirm_pkg::lane_req_t       req_reg;

    always_comb
    begin
        sx = (map_x >= width) ? width - lirm_pkg::X_W'(1) : map_x;
        sy = (map_y >= height) ? height - lirm_pkg::Y_W'(1) : map_y;
        src_idx = lirm_pkg::pair_index(sy, sx[lirm_pkg::X_W-1:1]);
        req_next.marked     = mark_en && (map_x == '0) && (map_y == '0);
        req_next.chroma_idx = src_idx;
        req_next.luma_idx   = req_next.marked ? dest_idx : src_idx;
        req_next.bank_odd   = req_next.marked ? odd_pixel : sx[0];
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    assign req = req_reg;

endmodule

/* hw/rtl/lirm_merge.sv */
// Merging stage of the remap block: picks the luma bank, applies marking and averages chroma.
// It depends on lirm_pkg.
module lirm_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid,
    input  lirm_pkg::lane_sel_t         sel_first,
    input  lirm_pkg::lane_sel_t         sel_second,
    input  logic [lirm_pkg::PIX_W-1:0]  luma_even_a,
    input  logic [lirm_pkg::PIX_W-1:0]  luma_even_b,
    input  logic [lirm_pkg::PIX_W-1:0]  luma_odd_a,
    input  logic [lirm_pkg::PIX_W-1:0]  luma_odd_b,
    input  logic [lirm_pkg::PIX_W-1:0]  u_a,
    input  logic [lirm_pkg::PIX_W-1:0]  u_b,
    input  logic [lirm_pkg::PIX_W-1:0]  v_a,
    input  logic [lirm_pkg::PIX_W-1:0]  v_b,
    output logic                        done,
    output logic [lirm_pkg::PIX_W-1:0]  out_luma_first,
    output logic [lirm_pkg::PIX_W-1:0]  out_luma_second,
    output logic [lirm_pkg::PIX_W-1:0]  out_chroma_u,
    output logic [lirm_pkg::PIX_W-1:0]  out_chroma_v
);

    logic [lirm_pkg::PIX_W-1:0] u0;
    logic [lirm_pkg::PIX_W-1:0] u1;
    logic [lirm_pkg::PIX_W-1:0] v0;
    logic [lirm_pkg::PIX_W-1:0] v1;
    logic [lirm_pkg::PIX_W:0]   u_sum;
    logic [lirm_pkg::PIX_W:0]   v_sum;
    logic                       done_reg;
    logic [lirm_pkg::PIX_W-1:0] luma_first_reg;
    logic [lirm_pkg::PIX_W-1:0] luma_second_reg;
    logic [lirm_pkg::PIX_W-1:0] chroma_u_reg;
    logic [lirm_pkg::PIX_W-1:0] chroma_v_reg;
    logic [lirm_pkg::PIX_W-1:0] luma_first_next;
    logic [lirm_pkg::PIX_W-1:0] luma_second_next;

    always_comb
    begin
        luma_first_next  = sel_first.bank_odd ? luma_odd_a : luma_even_a;
        luma_second_next = sel_second.bank_odd ? luma_odd_b : luma_even_b;
        u0 = sel_first.marked ? lirm_pkg::MARK_U : u_a;
        v0 = sel_first.marked ? lirm_pkg::MARK_V : v_a;
        u1 = sel_second.marked ? lirm_pkg::MARK_U : u_b;
        v1 = sel_second.marked ? lirm_pkg::MARK_V : v_b;
        u_sum = {1'b0, u0} + {1'b0, u1};
        v_sum = {1'b0, v0} + {1'b0, v1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        luma_first_reg  <= luma_first_next;
        luma_second_reg <= luma_second_next;
        chroma_u_reg    <= u_sum[lirm_pkg::PIX_W:1];
        chroma_v_reg    <= v_sum[lirm_pkg::PIX_W:1];
    end

    assign done            = done_reg;
    assign out_luma_first  = luma_first_reg;
    assign out_luma_second = luma_second_reg;
    assign out_chroma_u    = chroma_u_reg;
    assign out_chroma_v    = chroma_v_reg;

endmodule

/* hw/rtl/lut_image_remap_yuv422.sv */
// Top level of the lookup-table YUV422 remap block.
// It depends on lirm_pkg, lirm_ram, lirm_lane and lirm_merge.
//
// The block takes one transaction in every clock cycle and busy stays low. A load transaction
// inside the frame writes its pixel pair into the frame stores in the cycle after it is taken;
// a remap one passes the lane, store read and merge registers and gives its result with done
// high for one cycle. Results leave in the order the transactions came, one per cycle at most,
// and the receiver must take each one when done is high since it cannot hold the block off.
// The rate is set by the frame stores: luma is kept in an even and an odd bank, and every store
// has two read ports, so two address lanes fetch both pixels of a pair in the same cycle.
module lut_image_remap_yuv422 (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lirm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lirm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic                              mode,
    input  logic [lirm_pkg::X_W-1:0]          pos_x,
    input  logic [lirm_pkg::Y_W-1:0]          pos_y,
    input  logic [lirm_pkg::PIX_W-1:0]        luma_first,
    input  logic [lirm_pkg::PIX_W-1:0]        luma_second,
    input  logic [lirm_pkg::PIX_W-1:0]        chroma_u,
    input  logic [lirm_pkg::PIX_W-1:0]        chroma_v,
    input  logic [lirm_pkg::X_W-1:0]          map_first_x,
    input  logic [lirm_pkg::Y_W-1:0]          map_first_y,
    input  logic [lirm_pkg::X_W-1:0]          map_second_x,
    input  logic [lirm_pkg::Y_W-1:0]          map_second_y,
    output logic                              done,
    output logic [lirm_pkg::PIX_W-1:0]        out_luma_first,
    output logic [lirm_pkg::PIX_W-1:0]        out_luma_second,
    output logic [lirm_pkg::PIX_W-1:0]        out_chroma_u,
    output logic [lirm_pkg::PIX_W-1:0]        out_chroma_v
);

    logic [lirm_pkg::X_W-1:0]    width_reg;
    logic [lirm_pkg::Y_W-1:0]    height_reg;
    logic                        mark_reg;

    logic                        accept;
    logic [lirm_pkg::X_W-1:0]    px_even;
    logic [lirm_pkg::X_W-1:0]    dest_x;
    logic [lirm_pkg::Y_W-1:0]    dest_y;
    logic [lirm_pkg::ADDR_W-1:0] dest_idx;
    logic                        load_ok;

    logic                        remap_valid_reg;
    logic                        wr_valid_reg;
    logic [lirm_pkg::ADDR_W-1:0] wr_idx_reg;
    logic [lirm_pkg::PIX_W-1:0]  wr_luma_even_reg;
    logic [lirm_pkg::PIX_W-1:0]  wr_luma_odd_reg;
    logic [lirm_pkg::PIX_W-1:0]  wr_u_reg;
    logic [lirm_pkg::PIX_W-1:0]  wr_v_reg;

    logic                        fetch_valid_reg;
    lirm_pkg::lane_sel_t         sel_first_reg;
    lirm_pkg::lane_sel_t         sel_second_reg;

    lirm_pkg::lane_req_t         req_first;
    lirm_pkg::lane_req_t         req_second;

    logic [lirm_pkg::PIX_W-1:0]  luma_even_a;
    logic [lirm_pkg::PIX_W-1:0]  luma_even_b;
    logic [lirm_pkg::PIX_W-1:0]  luma_odd_a;
    logic [lirm_pkg::PIX_W-1:0]  luma_odd_b;
    logic [lirm_pkg::PIX_W-1:0]  u_a;
    logic [lirm_pkg::PIX_W-1:0]  u_b;
    logic [lirm_pkg::PIX_W-1:0]  v_a;
    logic [lirm_pkg::PIX_W-1:0]  v_b;

    // Registers hold the limited values, so the datapath never sees an out-of-range size.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= lirm_pkg::X_W'(lirm_pkg::MAX_WIDTH);
            height_reg <= lirm_pkg::Y_W'(lirm_pkg::MAX_HEIGHT);
            mark_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lirm_pkg::REG_FRAME_WIDTH:
                begin
                    width_reg <= lirm_pkg::eff_width(cfg_data);
                end
                lirm_pkg::REG_FRAME_HEIGHT:
                begin
                    height_reg <= lirm_pkg::eff_height(cfg_data[lirm_pkg::Y_W-1:0]);
                end
                lirm_pkg::REG_MARK_UNMAPPED:
                begin
                    mark_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        px_even  = {pos_x[lirm_pkg::X_W-1:1], 1'b0};
        load_ok  = (px_even < width_reg) && (pos_y < height_reg);
        dest_x   = (px_even > width_reg - lirm_pkg::X_W'(2)) ?
                   width_reg - lirm_pkg::X_W'(2) : px_even;
        dest_y   = (pos_y >= height_reg) ? height_reg - lirm_pkg::Y_W'(1) : pos_y;
        dest_idx = lirm_pkg::pair_index(mode ? dest_y : pos_y,
                                        mode ? dest_x[lirm_pkg::X_W-1:1]
                                             : px_even[lirm_pkg::X_W-1:1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remap_valid_reg <= 1'b0;
            wr_valid_reg    <= 1'b0;
            fetch_valid_reg <= 1'b0;
        end
        else
        begin
            remap_valid_reg <= accept && mode;
            wr_valid_reg    <= accept && !mode && load_ok;
            fetch_valid_reg <= remap_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_idx_reg       <= dest_idx;
        wr_luma_even_reg <= luma_first;
        wr_luma_odd_reg  <= luma_second;
        wr_u_reg         <= chroma_u;
        wr_v_reg         <= chroma_v;
        sel_first_reg    <= '{bank_odd: req_first.bank_odd, marked: req_first.marked};
        sel_second_reg   <= '{bank_odd: req_second.bank_odd, marked: req_second.marked};
    end

    lirm_lane u_lane_first (
        .clk       (clk),
        .map_x     (map_first_x),
        .map_y     (map_first_y),
        .width     (width_reg),
        .height    (height_reg),
        .mark_en   (mark_reg),
        .odd_pixel (1'b0),
        .dest_idx  (dest_idx),
        .req       (req_first)
    );

    lirm_lane u_lane_second (
        .clk       (clk),
        .map_x     (map_second_x),
        .map_y     (map_second_y),
        .width     (width_reg),
        .height    (height_reg),
        .mark_en   (mark_reg),
        .odd_pixel (1'b1),
        .dest_idx  (dest_idx),
        .req       (req_second)
    );

    lirm_ram #(
        .WIDTH (lirm_pkg::PIX_W),
        .DEPTH (lirm_pkg::STORE_DEPTH)
    ) u_luma_even (
        .clk     (clk),
        .we      (wr_valid_reg),
        .waddr   (wr_idx_reg),
        .wdata   (wr_luma_even_reg),
        .raddr_a (req_first.luma_idx),
        .raddr_b (req_second.luma_idx),
        .rdata_a (luma_even_a),
        .rdata_b (luma_even_b)
    );

    lirm_ram #(
        .WIDTH (lirm_pkg::PIX_W),
        .DEPTH (lirm_pkg::STORE_DEPTH)
    ) u_luma_odd (
        .clk     (clk),
        .we      (wr_valid_reg),
        .waddr   (wr_idx_reg),
        .wdata   (wr_luma_odd_reg),
        .raddr_a (req_first.luma_idx),
        .raddr_b (req_second.luma_idx),
        .rdata_a (luma_odd_a),
        .rdata_b (luma_odd_b)
    );

    lirm_ram #(
        .WIDTH (lirm_pkg::PIX_W),
        .DEPTH (lirm_pkg::STORE_DEPTH)
    ) u_chroma_u (
        .clk     (clk),
        .we      (wr_valid_reg),
        .waddr   (wr_idx_reg),
        .wdata   (wr_u_reg),
        .raddr_a (req_first.chroma_idx),
        .raddr_b (req_second.chroma_idx),
        .rdata_a (u_a),
        .rdata_b (u_b)
    );

    lirm_ram #(
        .WIDTH (lirm_pkg::PIX_W),
        .DEPTH (lirm_pkg::STORE_DEPTH)
    ) u_chroma_v (
        .clk     (clk),
        .we      (wr_valid_reg),
        .waddr   (wr_idx_reg),
        .wdata   (wr_v_reg),
        .raddr_a (req_first.chroma_idx),
        .raddr_b (req_second.chroma_idx),
        .rdata_a (v_a),
        .rdata_b (v_b)
    );

    lirm_merge u_merge (
        .clk             (clk),
        .rst_n           (rst_n),
        .valid           (fetch_valid_reg),
        .sel_first       (sel_first_reg),
        .sel_second      (sel_second_reg),
        .luma_even_a     (luma_even_a),
        .luma_even_b     (luma_even_b),
        .luma_odd_a      (luma_odd_a),
        .luma_odd_b      (luma_odd_b),
        .u_a             (u_a),
        .u_b             (u_b),
        .v_a             (v_a),
        .v_b             (v_b),
        .done            (done),
        .out_luma_first  (out_luma_first),
        .out_luma_second (out_luma_second),
        .out_chroma_u    (out_chroma_u),
        .out_chroma_v    (out_chroma_v)
    );

endmodule

/* tb/sv/tb_lut_image_remap_yuv422.sv */
// Self-checking testbench for lut_image_remap_yuv422: directed and random load and remap
// transactions over several frame settings, checked against an in-bench model of the frame.
// It depends on lirm_pkg and the lut_image_remap_yuv422 RTL.
module tb_lut_image_remap_yuv422;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PAIR_SLOTS    = lirm_pkg::CSTRIDE * lirm_pkg::MAX_HEIGHT;
    localparam int LUMA_SLOTS    = lirm_pkg::MAX_WIDTH * lirm_pkg::MAX_HEIGHT;
    localparam int PHASES        = 10;

    typedef struct packed {
        logic                       mode;
        logic [lirm_pkg::X_W-1:0]   pos_x;
        logic [lirm_pkg::Y_W-1:0]   pos_y;
        logic [lirm_pkg::PIX_W-1:0] luma_first;
        logic [lirm_pkg::PIX_W-1:0] luma_second;
        logic [lirm_pkg::PIX_W-1:0] chroma_u;
        logic [lirm_pkg::PIX_W-1:0] chroma_v;
        logic [lirm_pkg::X_W-1:0]   map_first_x;
        logic [lirm_pkg::Y_W-1:0]   map_first_y;
        logic [lirm_pkg::X_W-1:0]   map_second_x;
        logic [lirm_pkg::Y_W-1:0]   map_second_y;
    } pixel_txn_t;

    typedef struct packed {
        logic [lirm_pkg::PIX_W-1:0] luma_first;
        logic [lirm_pkg::PIX_W-1:0] luma_second;
        logic [lirm_pkg::PIX_W-1:0] chroma_u;
        logic [lirm_pkg::PIX_W-1:0] chroma_v;
    } remap_pair_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [lirm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [lirm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            start = 1'b0;
    logic                            busy;
    logic                            done;
    logic [lirm_pkg::PIX_W-1:0]      out_luma_first;
    logic [lirm_pkg::PIX_W-1:0]      out_luma_second;
    logic [lirm_pkg::PIX_W-1:0]      out_chroma_u;
    logic [lirm_pkg::PIX_W-1:0]      out_chroma_v;
    pixel_txn_t                      bus_txn = '0;

    pixel_txn_t  pending_txns[$];
    remap_pair_t expected_pairs[$];

    logic [lirm_pkg::PIX_W-1:0] luma_plane [LUMA_SLOTS];
    logic [lirm_pkg::PIX_W-1:0] u_plane [PAIR_SLOTS];
    logic [lirm_pkg::PIX_W-1:0] v_plane [PAIR_SLOTS];
    bit                         pair_loaded [PAIR_SLOTS];
    int unsigned                loaded_pairs[$];

    int width_reg = 640;
    int height_reg = 480;
    bit mark_reg = 1'b1;
    int gap_pct = 37;

    int issued_count = 0;
    int accepted_count = 0;
    int results_checked = 0;
    int fail_count = 0;
    int stall_cycles = 0;

    lut_image_remap_yuv422 dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .mode           (bus_txn.mode),
        .pos_x          (bus_txn.pos_x),
        .pos_y          (bus_txn.pos_y),
        .luma_first     (bus_txn.luma_first),
        .luma_second    (bus_txn.luma_second),
        .chroma_u       (bus_txn.chroma_u),
        .chroma_v       (bus_txn.chroma_v),
        .map_first_x    (bus_txn.map_first_x),
        .map_first_y    (bus_txn.map_first_y),
        .map_second_x   (bus_txn.map_second_x),
        .map_second_y   (bus_txn.map_second_y),
        .done           (done),
        .out_luma_first (out_luma_first),
        .out_luma_second(out_luma_second),
        .out_chroma_u   (out_chroma_u),
        .out_chroma_v   (out_chroma_v)
    );

    always #2 clk = ~clk;

    function automatic int frame_w_eff();
        int w;
        w = width_reg & 32'hFFFF_FFFE;
        if (w < 2) w = 2;
        if (w > lirm_pkg::MAX_WIDTH) w = lirm_pkg::MAX_WIDTH;
        return w;
    endfunction

    function automatic int frame_h_eff();
        int h;
        h = height_reg;
        if (h < 1) h = 1;
        if (h > lirm_pkg::MAX_HEIGHT) h = lirm_pkg::MAX_HEIGHT;
        return h;
    endfunction

    task automatic fetch_pixel(input int mx, input int my, input int dx, input int dy,
                               input int w, input int h,
                               output int luma, output int cu, output int cv);
        int sx;
        int sy;
        if (mark_reg && mx == 0 && my == 0)
        begin
            luma = luma_plane[dy * lirm_pkg::MAX_WIDTH + dx];
            cu   = lirm_pkg::MARK_U;
            cv   = lirm_pkg::MARK_V;
        end
        else
        begin
            sx   = (mx >= w) ? w - 1 : mx;
            sy   = (my >= h) ? h - 1 : my;
            luma = luma_plane[sy * lirm_pkg::MAX_WIDTH + sx];
            cu   = u_plane[sy * lirm_pkg::CSTRIDE + sx / 2];
            cv   = v_plane[sy * lirm_pkg::CSTRIDE + sx / 2];
        end
    endtask

    task automatic remap_predict(input pixel_txn_t t);
        int w;
        int h;
        int px;
        int py;
        int y1;
        int u1;
        int v1;
        int y2;
        int u2;
        int v2;
        remap_pair_t e;
        w  = frame_w_eff();
        h  = frame_h_eff();
        px = int'(t.pos_x) & 32'hFFFF_FFFE;
        py = int'(t.pos_y);
        if (t.mode == 1'b0)
        begin
            if (px < w && py < h)
            begin
                luma_plane[py * lirm_pkg::MAX_WIDTH + px]     = t.luma_first;
                luma_plane[py * lirm_pkg::MAX_WIDTH + px + 1] = t.luma_second;
                u_plane[py * lirm_pkg::CSTRIDE + px / 2]      = t.chroma_u;
                v_plane[py * lirm_pkg::CSTRIDE + px / 2]      = t.chroma_v;
            end
        end
        else
        begin
            if (px > w - 2) px = w - 2;
            if (py >= h) py = h - 1;
            fetch_pixel(int'(t.map_first_x), int'(t.map_first_y), px, py, w, h, y1, u1, v1);
            fetch_pixel(int'(t.map_second_x), int'(t.map_second_y), px + 1, py, w, h,
                        y2, u2, v2);
            e.luma_first  = y1[lirm_pkg::PIX_W-1:0];
            e.luma_second = y2[lirm_pkg::PIX_W-1:0];
            e.chroma_u    = 8'((u1 + u2) >> 1);
            e.chroma_v    = 8'((v1 + v2) >> 1);
            expected_pairs.push_back(e);
        end
    endtask

    task automatic check_result();
        remap_pair_t e;
        if (expected_pairs.size() == 0)
        begin
            $error("Remap result arrived with no transaction waiting for it");
            fail_count++;
        end
        else
        begin
            e = expected_pairs.pop_front();
            results_checked++;
            if (out_luma_first !== e.luma_first)
            begin
                $error("out_luma_first: expected %0d, got %0d", e.luma_first, out_luma_first);
                fail_count++;
            end
            if (out_luma_second !== e.luma_second)
            begin
                $error("out_luma_second: expected %0d, got %0d", e.luma_second,
                       out_luma_second);
                fail_count++;
            end
            if (out_chroma_u !== e.chroma_u)
            begin
                $error("out_chroma_u: expected %0d, got %0d", e.chroma_u, out_chroma_u);
                fail_count++;
            end
            if (out_chroma_v !== e.chroma_v)
            begin
                $error("out_chroma_v: expected %0d, got %0d", e.chroma_v, out_chroma_v);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        bit seen;
        seen = 1'b0;
        if (rst_n && start && !busy)
        begin
            remap_predict(bus_txn);
            accepted_count++;
            seen = 1'b1;
        end
        if (rst_n && done)
        begin
            check_result();
            seen = 1'b1;
        end
        if (seen) stall_cycles = 0;
        else stall_cycles++;
    end

    always @(negedge clk)
    begin
        if (rst_n && (!start || accepted_count == issued_count))
        begin
            if (pending_txns.size() != 0 && $urandom_range(0, 99) >= gap_pct)
            begin
                bus_txn <= pending_txns.pop_front();
                start   <= 1'b1;
                issued_count++;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    function automatic pixel_txn_t random_txn();
        pixel_txn_t t;
        t.mode         = 1'($urandom);
        t.pos_x        = lirm_pkg::X_W'($urandom);
        t.pos_y        = lirm_pkg::Y_W'($urandom);
        t.luma_first   = lirm_pkg::PIX_W'($urandom);
        t.luma_second  = lirm_pkg::PIX_W'($urandom);
        t.chroma_u     = lirm_pkg::PIX_W'($urandom);
        t.chroma_v     = lirm_pkg::PIX_W'($urandom);
        t.map_first_x  = lirm_pkg::X_W'($urandom);
        t.map_first_y  = lirm_pkg::Y_W'($urandom);
        t.map_second_x = lirm_pkg::X_W'($urandom);
        t.map_second_y = lirm_pkg::Y_W'($urandom);
        return t;
    endfunction

    task automatic add_load(input int x, input int y, input int l1, input int l2,
                            input int cu, input int cv);
        pixel_txn_t t;
        int px;
        int idx;
        t             = random_txn();
        t.mode        = 1'b0;
        t.pos_x       = lirm_pkg::X_W'(x);
        t.pos_y       = lirm_pkg::Y_W'(y);
        t.luma_first  = lirm_pkg::PIX_W'(l1);
        t.luma_second = lirm_pkg::PIX_W'(l2);
        t.chroma_u    = lirm_pkg::PIX_W'(cu);
        t.chroma_v    = lirm_pkg::PIX_W'(cv);
        pending_txns.push_back(t);
        px = x & 32'hFFFF_FFFE;
        if (px < frame_w_eff() && y < frame_h_eff())
        begin
            idx = y * lirm_pkg::CSTRIDE + px / 2;
            if (!pair_loaded[idx])
            begin
                pair_loaded[idx] = 1'b1;
                loaded_pairs.push_back(idx);
            end
        end
    endtask

    task automatic add_remap(input int x, input int y, input int fx, input int fy,
                             input int sx, input int sy);
        pixel_txn_t t;
        t              = random_txn();
        t.mode         = 1'b1;
        t.pos_x        = lirm_pkg::X_W'(x);
        t.pos_y        = lirm_pkg::Y_W'(y);
        t.map_first_x  = lirm_pkg::X_W'(fx);
        t.map_first_y  = lirm_pkg::Y_W'(fy);
        t.map_second_x = lirm_pkg::X_W'(sx);
        t.map_second_y = lirm_pkg::Y_W'(sy);
        pending_txns.push_back(t);
    endtask

    function automatic bit pixel_readable(int mx, int my, int dx, int dy);
        int w;
        int h;
        int sx;
        int sy;
        w = frame_w_eff();
        h = frame_h_eff();
        if (mark_reg && mx == 0 && my == 0) return pair_loaded[dy * lirm_pkg::CSTRIDE + dx / 2];
        sx = (mx >= w) ? w - 1 : mx;
        sy = (my >= h) ? h - 1 : my;
        return pair_loaded[sy * lirm_pkg::CSTRIDE + sx / 2];
    endfunction

    task automatic pick_source(output int mx, output int my);
        int r;
        int idx;
        int w;
        int h;
        w = frame_w_eff();
        h = frame_h_eff();
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            mx = 0;
            my = 0;
        end
        else
        begin
            idx = loaded_pairs[$urandom_range(0, loaded_pairs.size() - 1)];
            mx  = 2 * (idx % lirm_pkg::CSTRIDE) + $urandom_range(0, 1);
            my  = idx / lirm_pkg::CSTRIDE;
            if (r < 35)
            begin
                if (mx >= w - 1) mx = $urandom_range(w, 1023);
                if (my >= h - 1) my = $urandom_range(h, 511);
            end
        end
    endtask

    task automatic gen_random_remap(output bit ok);
        int tries;
        int w;
        int h;
        int x;
        int y;
        int dx;
        int dy;
        int idx;
        int fx;
        int fy;
        int sx;
        int sy;
        w  = frame_w_eff();
        h  = frame_h_eff();
        ok = 1'b0;
        for (tries = 0; tries < 30 && !ok; tries++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                idx = loaded_pairs[$urandom_range(0, loaded_pairs.size() - 1)];
                x   = 2 * (idx % lirm_pkg::CSTRIDE) + $urandom_range(0, 1);
                y   = idx / lirm_pkg::CSTRIDE;
            end
            else
            begin
                x = ($urandom_range(0, 99) < 80) ? $urandom_range(0, w - 1)
                                                 : $urandom_range(0, 1023);
                y = ($urandom_range(0, 99) < 80) ? $urandom_range(0, h - 1)
                                                 : $urandom_range(0, 511);
            end
            dx = x & 32'hFFFF_FFFE;
            if (dx > w - 2) dx = w - 2;
            dy = (y >= h) ? h - 1 : y;
            pick_source(fx, fy);
            pick_source(sx, sy);
            if (pixel_readable(fx, fy, dx, dy) && pixel_readable(sx, sy, dx + 1, dy))
            begin
                add_remap(x, y, fx, fy, sx, sy);
                ok = 1'b1;
            end
        end
    endtask

    task automatic gen_random_load();
        int w;
        int h;
        int r;
        int x;
        int y;
        w = frame_w_eff();
        h = frame_h_eff();
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            x = $urandom_range(0, 1023);
            y = $urandom_range(0, 511);
        end
        else
        begin
            if (r < 35) x = w - 2;
            else if (r < 55) x = 0;
            else x = 2 * $urandom_range(0, (w - 2) / 2);
            x = x + $urandom_range(0, 1);
            r = $urandom_range(0, 99);
            if (r < 30) y = h - 1;
            else if (r < 50) y = 0;
            else y = $urandom_range(0, h - 1);
        end
        add_load(x, y, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    task automatic wait_until_idle();
        while (pending_txns.size() != 0 || accepted_count != issued_count
               || expected_pairs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_frame_setting(input int w, input int h, input bit m);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= lirm_pkg::REG_FRAME_WIDTH;
        cfg_data  <= lirm_pkg::CFG_DATA_W'(w);
        @(negedge clk);
        cfg_index <= lirm_pkg::REG_FRAME_HEIGHT;
        cfg_data  <= lirm_pkg::CFG_DATA_W'(h);
        @(negedge clk);
        cfg_index <= lirm_pkg::REG_MARK_UNMAPPED;
        cfg_data  <= lirm_pkg::CFG_DATA_W'(m);
        @(negedge clk);
        cfg_we    <= 1'b0;
        width_reg  = w & 32'h3FF;
        height_reg = h & 32'h1FF;
        mark_reg   = m;
    endtask

    initial
    begin
        @(negedge clk);
        while (stall_cycles < STALL_LIMIT) @(negedge clk);
        $error("No transaction for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int ph;
        int w;
        int h;
        int n;
        int i;
        bit m;
        bit ok;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        write_frame_setting(640, 480, 1'b1);

        // Frame corners, extreme sample values and loads that fall outside the frame.
        add_load(0, 0, 0, 255, 0, 255);
        add_load(638, 0, 255, 0, 255, 0);
        add_load(0, 479, 128, 127, 1, 254);
        add_load(639, 479, 255, 255, 255, 255);
        add_load(700, 10, 11, 22, 33, 44);
        add_load(100, 500, 55, 66, 77, 88);
        add_load(2, 0, 17, 34, 51, 68);
        add_remap(0, 0, 1, 0, 638, 0);
        add_remap(0, 0, 0, 0, 0, 0);
        add_remap(638, 479, 0, 0, 639, 479);
        add_remap(100, 100, 1023, 0, 700, 479);
        add_remap(200, 200, 0, 511, 638, 480);
        add_remap(1023, 511, 0, 0, 0, 0);
        add_remap(1, 0, 0, 0, 3, 0);
        add_remap(0, 0, 2, 0, 639, 511);

        for (ph = 1; ph <= PHASES; ph++)
        begin
            wait_until_idle();
            gap_pct = 37;
            case (ph)
                1:
                begin
                    w = 8;
                    h = 4;
                    m = 1'b1;
                    n = 150;
                end
                2:
                begin
                    w = 2;
                    h = 1;
                    m = 1'b1;
                    n = 60;
                end
                3:
                begin
                    w = 1;
                    h = 0;
                    m = 1'b0;
                    n = 60;
                end
                4:
                begin
                    w = 640;
                    h = 480;
                    m = 1'b0;
                    n = 180;
                    gap_pct = 0;
                end
                5:
                begin
                    w = 13;
                    h = 7;
                    m = 1'b1;
                    n = 160;
                end
                6:
                begin
                    w = 1023;
                    h = 511;
                    m = 1'b1;
                    n = 160;
                end
                default:
                begin
                    w = 2 * $urandom_range(1, 32);
                    h = $urandom_range(1, 40);
                    m = 1'($urandom_range(0, 1));
                    n = 150;
                end
            endcase
            write_frame_setting(w, h, m);
            add_load(0, 0, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255));
            add_load(frame_w_eff() - 2, frame_h_eff() - 1, $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
            for (i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 99) < 40)
                begin
                    gen_random_load();
                end
                else
                begin
                    gen_random_remap(ok);
                    if (!ok) gen_random_load();
                end
            end
        end

        wait_until_idle();
        fail_count += expected_pairs.size();
        $display("Run covered %0d transactions over %0d frame settings.",
                 accepted_count, PHASES + 1);
        $display("It checked %0d remapped pairs.", results_checked);
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/lirm_pkg.sv
hw/rtl/lirm_ram.sv
hw/rtl/lirm_lane.sv
hw/rtl/lirm_merge.sv
hw/rtl/lut_image_remap_yuv422.sv
tb/sv/tb_lut_image_remap_yuv422.sv
